/* hw/rtl/psfc_pkg.sv */
// ----------------------------------------------------------------------------
// psfc_pkg
// shared types and constants of the stuffing framer with frame crc
// ----------------------------------------------------------------------------
package psfc_pkg;

  localparam int MAX_FRAME_BITS_DEF   = 4096;
  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int MAX_CRC_DEGREE_DEF   = 63;
  localparam int MAX_RES              = 56;

  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_L  = 8'h4C;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    REG_PACKET_BYTES = 2'd0,
    REG_FRAME_BITS   = 2'd1,
    REG_CRC_DEGREE   = 2'd2,
    REG_CRC_POLY     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [3:0]  valid_bits;
    logic        frame_end;
    logic [11:0] padding_bits;
    logic [62:0] crc_value;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic accept;
    logic push_bit;
    logic emit_full;
    logic close_init;
    logic pad_step;
    logic close_emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic q_empty;
    logic full_byte;
    logic close_hit;
    logic pad_done;
    logic emit_ok;
    logic out_free;
    logic hold_v;
    logic end_pkt;
    logic fbc_nz;
  } sts_t;

endpackage

/* hw/rtl/psfc_stream_if.sv */
// ----------------------------------------------------------------------------
// psfc_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface psfc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/psfc_ctrl.sv */
// ----------------------------------------------------------------------------
// psfc_ctrl
// sequencer: walks the stuffed bits, frame close and result drain
// ----------------------------------------------------------------------------
module psfc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  psfc_pkg::sts_t sts,
  output psfc_pkg::cmd_t cmd
);
  import psfc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_CINIT = 6'b000100,
    ST_CPAD  = 6'b001000,
    ST_CEMIT = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts.q_empty) begin
          if (!(sts.full_byte && !sts.emit_ok)) begin
            cmd.push_bit  = 1'b1;
            cmd.emit_full = sts.full_byte;
            if (sts.close_hit) state_nxt = ST_CINIT;
          end
        end else if (sts.end_pkt && sts.fbc_nz) begin
          state_nxt = ST_CINIT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CINIT: begin
        cmd.close_init = 1'b1;
        state_nxt      = ST_CPAD;
      end
      ST_CPAD: begin
        if (sts.pad_done) state_nxt = ST_CEMIT;
        else cmd.pad_step = 1'b1;
      end
      ST_CEMIT: begin
        if (sts.emit_ok) begin
          cmd.close_emit = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      ST_FIN: begin
        if (!sts.hold_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_RUN)
    else $error("accept did not start a run");
  a_emit_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close_emit |=> state_r == ST_RUN)
    else $error("close did not return to run");

endmodule

/* hw/rtl/psfc_dp.sv */
// ----------------------------------------------------------------------------
// psfc_dp
// datapath: config, stuffing window, bit repacker, serial crc, result regs
// ----------------------------------------------------------------------------
module psfc_dp #(
  parameter int MAX_FRAME_BITS   = psfc_pkg::MAX_FRAME_BITS_DEF,
  parameter int MAX_PACKET_BYTES = psfc_pkg::MAX_PACKET_BYTES_DEF,
  parameter int MAX_CRC_DEGREE   = psfc_pkg::MAX_CRC_DEGREE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [62:0]    cfg_wdata,
  input  psfc_pkg::in_t  in_data,
  output psfc_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_ready,
  input  psfc_pkg::cmd_t cmd,
  output psfc_pkg::sts_t sts
);
  import psfc_pkg::*;

  localparam int CW  = MAX_CRC_DEGREE;
  localparam int PCW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int FCW = $clog2(MAX_FRAME_BITS + 2);

  logic [11:0]    pkt_bytes_r;
  logic [12:0]    frame_bits_r;
  logic [5:0]     crc_deg_r;
  logic [CW-1:0]  crc_poly_r;

  logic [7:0]     win0_r, win1_r;
  logic [1:0]     wcnt_r;
  logic [PCW-1:0] pcnt_r;
  logic [FCW-1:0] fbc_r;
  logic [7:0]     pbyte_r;
  logic [3:0]     pbits_r;
  logic [CW-1:0]  crc_r;
  logic [55:0]    q_r;
  logic [5:0]     qcnt_r;
  logic           end_r;
  logic [3:0]     k_r;
  out_t           hold_r, out_r;
  logic           hold_v_r, out_v_r;
  logic [5:0]     rc_r;

  // effective config values
  logic [5:0]     deg_eff;
  logic [CW-1:0]  deg_mask;
  logic [FCW-1:0] fb_eff;
  logic [PCW-1:0] pb_eff;

  always_comb begin
    deg_eff  = (32'(crc_deg_r) > 32'(MAX_CRC_DEGREE)) ? 6'(MAX_CRC_DEGREE) : crc_deg_r;
    deg_mask = ~({CW{1'b1}} << deg_eff);
    if (frame_bits_r == '0) fb_eff = FCW'(1);
    else if (32'(frame_bits_r) > 32'(MAX_FRAME_BITS)) fb_eff = FCW'(MAX_FRAME_BITS);
    else fb_eff = FCW'(frame_bits_r);
    if (pkt_bytes_r == '0) pb_eff = PCW'(1);
    else if (32'(pkt_bytes_r) > 32'(MAX_PACKET_BYTES)) pb_eff = PCW'(MAX_PACKET_BYTES);
    else pb_eff = PCW'(pkt_bytes_r);
  end

  function automatic logic [CW-1:0] crc_step(input logic [CW-1:0] c, input logic b,
                                             input logic [5:0] d, input logic [CW-1:0] m,
                                             input logic [CW-1:0] p);
    logic          fbk;
    logic [CW-1:0] n;
    fbk = (d != '0) && ((c & (CW'(1) << (d - 6'd1))) != '0);
    n   = ((c << 1) | CW'(b)) & m;
    if (fbk) n = n ^ (p & m);
    return n;
  endfunction

  // stuffing window and byte queue built at accept
  logic [PCW-1:0] pcnt_inc;
  logic           end_c, trip;
  logic [55:0]    q_c;
  logic [2:0]     n_c;
  logic [1:0]     wcnt_c;
  logic [7:0]     w0_c, w1_c, b;

  always_comb begin
    b        = in_data.msg_byte;
    pcnt_inc = pcnt_r + PCW'(1);
    end_c    = in_data.msg_last || (pcnt_inc >= pb_eff);
    trip     = (win0_r == CH_D && win1_r == CH_L && b == CH_E) ||
               (win0_r == CH_E && win1_r == CH_T && b == CH_X) ||
               (win0_r == CH_S && win1_r == CH_T && b == CH_X);
    q_c    = '0;
    n_c    = '0;
    wcnt_c = wcnt_r;
    w0_c   = win0_r;
    w1_c   = win1_r;
    if (wcnt_r[1]) begin
      if (trip) begin
        q_c    = {CH_D, CH_L, CH_E, CH_SP, win0_r, win1_r, b};
        n_c    = 3'd7;
        wcnt_c = 2'd0;
      end else begin
        w0_c = win1_r;
        w1_c = b;
        if (end_c) begin
          q_c    = {win0_r, win1_r, b, 32'd0};
          n_c    = 3'd3;
          wcnt_c = 2'd0;
        end else begin
          q_c    = {win0_r, 48'd0};
          n_c    = 3'd1;
          wcnt_c = 2'd2;
        end
      end
    end else if (wcnt_r[0]) begin
      w1_c = b;
      if (end_c) begin
        q_c    = {win0_r, b, 40'd0};
        n_c    = 3'd2;
        wcnt_c = 2'd0;
      end else begin
        wcnt_c = 2'd2;
      end
    end else begin
      w0_c = b;
      if (end_c) begin
        q_c    = {b, 48'd0};
        n_c    = 3'd1;
        wcnt_c = 2'd0;
      end else begin
        wcnt_c = 2'd1;
      end
    end
  end

  // results
  logic [FCW-1:0] pad_w;
  out_t           full_res, close_res, new_res;
  logic           emit_now, can_store, out_free;
  out_t           out_nxt;
  logic           out_v_nxt;

  always_comb begin
    pad_w    = (fbc_r < fb_eff) ? (fb_eff - fbc_r) : '0;
    full_res = '{payload_byte: pbyte_r, valid_bits: 4'd8, frame_end: 1'b0,
                 padding_bits: '0, crc_value: '0, last_of_run: 1'b0};
    close_res = '{payload_byte: pbits_r[3] ? pbyte_r : (pbyte_r << (4'd8 - pbits_r)),
                  valid_bits: pbits_r, frame_end: 1'b1, padding_bits: 12'(pad_w),
                  crc_value: 63'(crc_r & deg_mask), last_of_run: 1'b0};
    new_res   = cmd.close_emit ? close_res : full_res;
    emit_now  = cmd.emit_full || cmd.close_emit;
    can_store = rc_r < 6'(MAX_RES);
    out_free  = !out_v_r || out_ready;
  end

  // output stage next value
  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_ready;
    if (emit_now && can_store && hold_v_r) begin
      out_nxt   = hold_r;
      out_v_nxt = 1'b1;
    end
    if (cmd.finish) begin
      out_nxt             = hold_r;
      out_nxt.last_of_run = 1'b1;
      out_v_nxt           = 1'b1;
    end
  end

  always_comb begin
    sts.q_empty   = qcnt_r == '0;
    sts.full_byte = pbits_r[3];
    sts.close_hit = (fbc_r + FCW'(1)) >= fb_eff;
    sts.pad_done  = k_r[3];
    sts.emit_ok   = !hold_v_r || out_free || !can_store;
    sts.out_free  = out_free;
    sts.hold_v    = hold_v_r;
    sts.end_pkt   = end_r;
    sts.fbc_nz    = fbc_r != '0;
  end

  assign out_data  = out_r;
  assign out_valid = out_v_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_bytes_r  <= 12'd2;
      frame_bits_r <= 13'd8;
      crc_deg_r    <= 6'd8;
      crc_poly_r   <= CW'(7);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_PACKET_BYTES: pkt_bytes_r  <= cfg_wdata[11:0];
        REG_FRAME_BITS:   frame_bits_r <= cfg_wdata[12:0];
        REG_CRC_DEGREE:   crc_deg_r    <= cfg_wdata[5:0];
        REG_CRC_POLY:     crc_poly_r   <= CW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r   <= '0;
      win1_r   <= '0;
      wcnt_r   <= '0;
      pcnt_r   <= '0;
      fbc_r    <= '0;
      pbyte_r  <= '0;
      pbits_r  <= '0;
      crc_r    <= '0;
      qcnt_r   <= '0;
      end_r    <= 1'b0;
      k_r      <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      rc_r     <= '0;
    end else begin
      out_v_r <= out_v_nxt;
      out_r   <= out_nxt;
      if (cmd.accept) begin
        win0_r <= w0_c;
        win1_r <= w1_c;
        wcnt_r <= wcnt_c;
        pcnt_r <= end_c ? '0 : pcnt_inc;
        q_r    <= q_c;
        qcnt_r <= {n_c, 3'b000};
        end_r  <= end_c;
        rc_r   <= '0;
      end
      if (cmd.push_bit) begin
        q_r     <= q_r << 1;
        qcnt_r  <= qcnt_r - 6'd1;
        pbyte_r <= {(cmd.emit_full ? 7'd0 : pbyte_r[6:0]), q_r[55]};
        pbits_r <= (cmd.emit_full ? 4'd0 : pbits_r) + 4'd1;
        crc_r   <= crc_step(crc_r, q_r[55], deg_eff, deg_mask, crc_poly_r);
        fbc_r   <= fbc_r + FCW'(1);
      end
      if (cmd.close_init) k_r <= pbits_r;
      if (cmd.pad_step) begin
        k_r   <= k_r + 4'd1;
        crc_r <= crc_step(crc_r, 1'b0, deg_eff, deg_mask, crc_poly_r);
      end
      if (cmd.close_emit) begin
        pbyte_r <= '0;
        pbits_r <= '0;
        fbc_r   <= '0;
        crc_r   <= '0;
      end
      if (emit_now && can_store) begin
        hold_r   <= new_res;
        hold_v_r <= 1'b1;
        rc_r     <= rc_r + 6'd1;
      end
      if (cmd.finish) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  a_pbits: assert property (@(posedge clk) disable iff (!rst_n) pbits_r <= 4'd8)
    else $error("partial byte overfull");
  a_rc: assert property (@(posedge clk) disable iff (!rst_n) rc_r <= 6'(MAX_RES))
    else $error("result count overrun");
  a_wcnt: assert property (@(posedge clk) disable iff (!rst_n) wcnt_r != 2'd3)
    else $error("window count out of range");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close_emit |=> fbc_r == '0 && pbits_r == '0)
    else $error("frame not cleared after close");

endmodule

/* hw/rtl/packet_stuff_frame_crc.sv */
// ----------------------------------------------------------------------------
// packet_stuff_frame_crc
// character-stuffing framer with per-frame serial crc
// ----------------------------------------------------------------------------
// flow: stuffed bits pass one at a time through the single-bit repacker and
//   serial crc; a frame close loads the held bit count, runs zero bits through
//   the crc up to a full byte, then emits the closing result; each transfer
//   also passes through accept and drain steps
// throughput: one item at a time; the next transfer is taken once all results
//   of the current one have moved into the output stages
// reset: synchronous active-low, config back to defaults, stream state cleared
module packet_stuff_frame_crc #(
  parameter int MAX_FRAME_BITS   = psfc_pkg::MAX_FRAME_BITS_DEF,
  parameter int MAX_PACKET_BYTES = psfc_pkg::MAX_PACKET_BYTES_DEF,
  parameter int MAX_CRC_DEGREE   = psfc_pkg::MAX_CRC_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  psfc_stream_if.sink   in_ch,
  psfc_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [62:0] cfg_wdata
);
  import psfc_pkg::*;

  cmd_t cmd;   // sequencer commands
  sts_t sts;   // datapath status

  // sequencer: in_ready only while idle
  psfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: hold stage keeps the latest result until we know if it closes the run
  psfc_dp #(
    .MAX_FRAME_BITS   (MAX_FRAME_BITS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .MAX_CRC_DEGREE   (MAX_CRC_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
